FILE: rtl/lyap_pkg.sv
// Shared types and constants for the Lyapunov exponent pixel core.
// Used by lyap_ctrl, lyap_datapath and the top level; depends on nothing.
package lyap_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int MAX_SEQ_DEF   = 16;
  localparam int MAX_ITER_DEF  = 4095;

  localparam int CFG_W   = 16;
  localparam int PAT_W   = 16;
  localparam int LEN_REG_W = 5;
  localparam int N_W     = 12;
  localparam int Q_W     = 12;
  localparam int BIT_W   = 4;

  localparam logic [1:0] REG_SEQ_PATTERN = 2'd0;
  localparam logic [1:0] REG_SEQ_LENGTH  = 2'd1;
  localparam logic [1:0] REG_ITER_COUNT  = 2'd2;

  localparam logic [PAT_W-1:0]     PATTERN_RST = 16'd4032;
  localparam logic [LEN_REG_W-1:0] LENGTH_RST  = 5'd12;
  localparam logic [N_W-1:0]       COUNT_RST   = 12'd400;

  // 100 * ln2 in Q16.
  localparam int SCALE_W = 23;
  localparam logic [SCALE_W-1:0] SCALE_K = 23'd4542600;
  localparam int SPLIT = 17;

  localparam logic [16:0] LOG2_TAB [33] = '{
    17'd0, 17'd2909, 17'd5732, 17'd8473, 17'd11136, 17'd13727, 17'd16248, 17'd18704,
    17'd21098, 17'd23433, 17'd25711, 17'd27936, 17'd30109, 17'd32234, 17'd34312,
    17'd36346, 17'd38336, 17'd40286, 17'd42196, 17'd44068, 17'd45904, 17'd47705,
    17'd49472, 17'd51207, 17'd52911, 17'd54584, 17'd56229, 17'd57845, 17'd59434,
    17'd60997, 17'd62534, 17'd64047, 17'd65536
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_RX, ST_DV, ST_NRM, ST_LOG, ST_MLO, ST_MHI, ST_DINIT, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             sq;
    logic             rx;
    logic             dv;
    logic             nrm;
    logic             lg;
    logic             mlo;
    logic             mhi;
    logic             dinit;
    logic             dstep;
    logic             use_a;
    logic [BIT_W-1:0] bit_idx;
    logic [N_W-1:0]   n;
  } cmd_t;

endpackage

FILE: rtl/lyap_datapath.sv
// Datapath of the Lyapunov pixel core: map update, derivative, log2 and final scaling.
// Driven by lyap_ctrl through cmd_t; uses lyap_pkg.
module lyap_datapath import lyap_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_ITER  = MAX_ITER_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [FRAC_BITS+2:0] rate_a,
  input  logic [FRAC_BITS+2:0] rate_b,
  output logic [Q_W-1:0]       exponent_level
);

  localparam int R_W   = FRAC_BITS + 3;
  localparam int X_W   = FRAC_BITS + 1;
  localparam int E_W   = $clog2(R_W);
  localparam int SUM_W = $clog2(R_W) + 16 + $clog2(MAX_ITER + 1) + 2;
  localparam int P_W   = SUM_W + SCALE_W;
  localparam int PQ_W  = P_W - 32;
  localparam int REM_W = (PQ_W > N_W + Q_W + 1) ? PQ_W : N_W + Q_W + 1;

  localparam logic [X_W-1:0] ONE  = X_W'(1) << FRAC_BITS;
  localparam logic [R_W-1:0] RMAX = R_W'(1) << (FRAC_BITS + 2);

  logic [R_W-1:0]          ra, rb, r;
  logic [X_W-1:0]          x, d;
  logic [2*X_W-1:0]        m1;
  logic [R_W-1:0]          v;
  logic [E_W-1:0]          e;
  logic [15:0]             f16;
  logic                    nz;
  logic signed [SUM_W-1:0] sum;
  logic [P_W-1:0]          p;
  logic [REM_W-1:0]        rem;
  logic [Q_W-1:0]          q;
  logic                    sat;

  logic [X_W-1:0]          y;
  logic [R_W+X_W-1:0]      rx_prod, dv_prod;
  logic [R_W+X_W-1:0]      x_full;
  logic [X_W:0]            x2;
  logic [E_W-1:0]          e_c;
  logic [R_W-1:0]          vn;
  logic [4:0]              seg;
  logic [10:0]             t;
  logic [16:0]             lo, hi, diff;
  logic [27:0]             ip;
  logic [16:0]             part;
  logic signed [SUM_W-1:0] term;
  logic [SUM_W-1:0]        mag;
  logic [REM_W-1:0]        dsh;
  logic [PQ_W-1:0]         pq;

  assign r = cmd.use_a ? ra : rb;
  assign y = X_W'(m1 >> FRAC_BITS);
  assign rx_prod = r * y;
  assign x_full = rx_prod >> FRAC_BITS;
  assign x2 = {x, 1'b0};
  assign d = (x2 >= {1'b0, ONE}) ? X_W'(x2 - {1'b0, ONE}) : X_W'({1'b0, ONE} - x2);
  assign dv_prod = r * d;

  always_comb begin
    e_c = '0;
    for (int i = 0; i < R_W; i++) begin
      if (v[i]) begin
        e_c = E_W'(i);
      end
    end
  end
  assign vn = v << (E_W'(R_W - 1) - e_c);

  assign seg  = f16[15:11];
  assign t    = f16[10:0];
  assign lo   = LOG2_TAB[seg];
  assign hi   = LOG2_TAB[6'({1'b0, seg}) + 6'd1];
  assign diff = hi - lo;
  assign ip   = diff * t;
  assign part = lo + 17'(ip >> 11);
  assign term = ((SUM_W'(e) - SUM_W'(FRAC_BITS)) <<< 16) + SUM_W'(part);

  assign mag = (sum < 0) ? SUM_W'(-sum) : SUM_W'(sum);
  assign pq  = p[P_W-1:32];
  assign dsh = REM_W'(cmd.n) << cmd.bit_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ra <= (rate_a > RMAX) ? RMAX : rate_a;
      rb <= (rate_b > RMAX) ? RMAX : rate_b;
      x  <= ONE >> 1;
      v  <= '0;
    end
    if (cmd.sq) begin
      m1 <= x * (ONE - x);
    end
    if (cmd.rx) begin
      x <= (x_full > (R_W+X_W)'(ONE)) ? ONE : X_W'(x_full);
    end
    if (cmd.dv) begin
      v <= R_W'(dv_prod >> FRAC_BITS);
    end
    if (cmd.nrm) begin
      e   <= e_c;
      f16 <= vn[R_W-2 -: 16];
    end
    if (cmd.mlo) begin
      p <= P_W'(mag[SPLIT-1:0] * SCALE_K);
    end
    if (cmd.mhi) begin
      p <= p + (P_W'(mag[SUM_W-1:SPLIT] * SCALE_K) << SPLIT);
    end
    if (cmd.dinit) begin
      rem <= REM_W'(pq);
    end
    if (cmd.dstep && rem >= dsh) begin
      rem <= rem - dsh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nz  <= 1'b0;
      sum <= '0;
      q   <= '0;
      sat <= 1'b0;
    end else begin
      if (cmd.load) begin
        nz  <= 1'b0;
        sum <= '0;
        q   <= '0;
        sat <= 1'b0;
      end
      if (cmd.nrm) begin
        nz <= (v != '0);
      end
      if (cmd.lg && nz) begin
        sum <= sum + term;
      end
      if (cmd.dinit) begin
        q   <= '0;
        sat <= REM_W'(pq) >= (REM_W'(cmd.n) << Q_W);
      end
      if (cmd.dstep && rem >= dsh) begin
        q[cmd.bit_idx] <= 1'b1;
      end
    end
  end

  assign exponent_level = sat ? '1 : q;

endmodule

FILE: rtl/lyap_ctrl.sv
// Sequencer of the Lyapunov pixel core: step count, sequence phase and command issue.
// Drives lyap_datapath through cmd_t; uses lyap_pkg.
module lyap_ctrl import lyap_pkg::*; #(
  parameter int MAX_SEQ  = MAX_SEQ_DEF,
  parameter int MAX_ITER = MAX_ITER_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [PAT_W-1:0]     seq_pattern,
  input  logic [LEN_REG_W-1:0] seq_length,
  input  logic [N_W-1:0]       iteration_count,
  output logic                 busy,
  output logic                 done,
  output cmd_t                 cmd
);

  localparam int LEN_W = $clog2(MAX_SEQ + 1);
  localparam int PH_W  = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;

  state_t           state, state_next;
  logic [LEN_W-1:0] len_eff, len_in;
  logic [PH_W-1:0]  phase;
  logic [N_W-1:0]   cnt, n_eff, n_in;
  logic [BIT_W-1:0] bit_idx;
  logic [6:0]       ph7;
  logic [LEN_W:0]   ph_inc;

  assign len_in = (seq_length == '0) ? LEN_W'(1) :
                  (32'(seq_length) > MAX_SEQ) ? LEN_W'(MAX_SEQ) : LEN_W'(seq_length);
  assign n_in   = (32'(iteration_count) > MAX_ITER) ? N_W'(MAX_ITER) : iteration_count;
  assign ph7    = 7'(phase);
  assign ph_inc = (LEN_W+1)'(phase) + (LEN_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      phase   <= '0;
      cnt     <= '0;
      len_eff <= LEN_W'(1);
      n_eff   <= '0;
      bit_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start) begin
        phase   <= '0;
        cnt     <= '0;
        len_eff <= len_in;
        n_eff   <= n_in;
      end
      if (state == ST_DV) begin
        cnt   <= cnt + N_W'(1);
        phase <= (ph_inc >= (LEN_W+1)'(len_eff)) ? '0 : PH_W'(ph_inc);
      end
      if (state == ST_DINIT) begin
        bit_idx <= BIT_W'(Q_W - 1);
      end
      if (state == ST_DIV) begin
        bit_idx <= bit_idx - BIT_W'(1);
      end
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.use_a   = (ph7 < 7'd16) && seq_pattern[ph7[3:0]];
    cmd.bit_idx = bit_idx;
    cmd.n       = n_eff;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (n_in == '0) ? ST_OUT : ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq     = 1'b1;
        cmd.nrm    = 1'b1;
        state_next = ST_RX;
      end
      ST_RX: begin
        cmd.rx     = 1'b1;
        cmd.lg     = 1'b1;
        state_next = ST_DV;
      end
      ST_DV: begin
        cmd.dv     = 1'b1;
        state_next = (cnt == n_eff - N_W'(1)) ? ST_NRM : ST_SQ;
      end
      ST_NRM: begin
        cmd.nrm    = 1'b1;
        state_next = ST_LOG;
      end
      ST_LOG: begin
        cmd.lg     = 1'b1;
        state_next = ST_MLO;
      end
      ST_MLO: begin
        cmd.mlo    = 1'b1;
        state_next = ST_MHI;
      end
      ST_MHI: begin
        cmd.mhi    = 1'b1;
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.dinit  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.dstep  = 1'b1;
        if (bit_idx == '0) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_OUT);

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> $past(done))
    else $error("busy dropped without a result beat");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((LEN_W+1)'(phase) < (LEN_W+1)'(len_eff)))
    else $error("sequence phase out of range");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DV) |-> (cnt < n_eff))
    else $error("step count passed the iteration count");
`endif

endmodule

FILE: rtl/lyapunov_exponent_pixel_core.sv
// Markus-Lyapunov pixel core on the logistic map. Pulse start while busy is low with the
// two Q3.24 rates on rate_a and rate_b; the result beat later appears on exponent_level with
// done high for a single cycle, and the receiver cannot stall it. Each map step runs through
// square, map update and derivative multiply, and the log, scaling and a 12-step divide
// follow the last step; when N = iteration_count is zero the core goes straight to done. The
// next start is taken in the cycle after done. Depends on lyap_pkg, lyap_ctrl and
// lyap_datapath; write configuration only while busy is low.
module lyapunov_exponent_pixel_core import lyap_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_SEQ   = MAX_SEQ_DEF,
  parameter int MAX_ITER  = MAX_ITER_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [FRAC_BITS+2:0] rate_a,
  input  logic [FRAC_BITS+2:0] rate_b,
  output logic                 done,
  output logic [Q_W-1:0]       exponent_level,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [PAT_W-1:0]     seq_pattern;
  logic [LEN_REG_W-1:0] seq_length;
  logic [N_W-1:0]       iteration_count;
  cmd_t                 cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_pattern     <= PATTERN_RST;
      seq_length      <= LENGTH_RST;
      iteration_count <= COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEQ_PATTERN: seq_pattern     <= cfg_data[PAT_W-1:0];
        REG_SEQ_LENGTH:  seq_length      <= cfg_data[LEN_REG_W-1:0];
        REG_ITER_COUNT:  iteration_count <= cfg_data[N_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lyap_ctrl #(
    .MAX_SEQ  (MAX_SEQ),
    .MAX_ITER (MAX_ITER)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .seq_pattern     (seq_pattern),
    .seq_length      (seq_length),
    .iteration_count (iteration_count),
    .busy            (busy),
    .done            (done),
    .cmd             (cmd)
  );

  lyap_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_ITER  (MAX_ITER)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rate_a         (rate_a),
    .rate_b         (rate_b),
    .exponent_level (exponent_level)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for lyapunov_exponent_pixel_core: drives pixels of two rates,
// predicts each exponent level in fixed point and compares it with the core's output.
// Depends on lyap_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
  import lyap_pkg::*;

  localparam int FB = 24;
  localparam int RW = FB + 3;
  localparam logic [RW-1:0] RATE_MAX = 27'd67108864;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [RW-1:0] rate_a = '0;
  logic [RW-1:0] rate_b = '0;
  logic done;
  logic [Q_W-1:0] exponent_level;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_SEQ_PATTERN;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [15:0] pattern_q = 16'd4032;
  logic [4:0] length_q = 5'd12;
  logic [11:0] count_q = 12'd400;
  logic [11:0] level_q[$];
  int errors = 0;

  localparam int unsigned LOG_TAB[33] = '{
    0, 2909, 5732, 8473, 11136, 13727, 16248, 18704, 21098, 23433, 25711, 27936, 30109,
    32234, 34312, 36346, 38336, 40286, 42196, 44068, 45904, 47705, 49472, 51207, 52911,
    54584, 56229, 57845, 59434, 60997, 62534, 64047, 65536
  };

  lyapunov_exponent_pixel_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .rate_a(rate_a), .rate_b(rate_b),
    .done(done), .exponent_level(exponent_level), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #400ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint unsigned rate_mul(longint unsigned r, longint unsigned y);
    return (r >> FB) * y + (((r & ((64'd1 << FB) - 1)) * y) >> FB);
  endfunction

  function automatic longint log2_q16(longint unsigned v);
    int e;
    longint unsigned rest, f16, seg, t, part;
    e = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    rest = v - (64'd1 << e);
    f16 = (e >= 16) ? (rest >> (e - 16)) : (rest << (16 - e));
    seg = (f16 >> 11) & 31;
    t = f16 & 2047;
    part = LOG_TAB[seg] + (((LOG_TAB[seg + 1] - LOG_TAB[seg]) * t) >> 11);
    return longint'(e - FB) * 65536 + longint'(part);
  endfunction

  function automatic logic [11:0] pixel_level(logic [RW-1:0] a, logic [RW-1:0] b);
    longint unsigned one, ra, rb, x, r, d, v, mag, lvl;
    longint sum;
    int len, phase;
    one = 64'd1 << FB;
    ra = (a > RATE_MAX) ? RATE_MAX : a;
    rb = (b > RATE_MAX) ? RATE_MAX : b;
    len = (length_q == 0) ? 1 : (length_q > 16 ? 16 : length_q);
    x = one >> 1;
    phase = 0;
    sum = 0;
    if (count_q == 0) return '0;
    for (int i = 0; i < count_q; i++) begin
      r = pattern_q[phase] ? ra : rb;
      x = rate_mul(r, (x * (one - x)) >> FB);
      if (x > one) x = one;
      d = (2 * x >= one) ? 2 * x - one : one - 2 * x;
      v = rate_mul(r, d);
      if (v != 0) sum += log2_q16(v);
      phase++;
      if (phase >= len) phase = 0;
    end
    mag = (sum < 0) ? longint'(-sum) : sum;
    lvl = (mag * 100 * 45426) / (longint'(count_q) << 32);
    return (lvl > 4095) ? 12'd4095 : lvl[11:0];
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (level_q.size() == 0) begin
        $error("exponent_level: none expected, actual %0d", exponent_level);
        errors++;
      end else begin
        logic [11:0] want;
        want = level_q.pop_front();
        if (want !== exponent_level) begin
          $error("exponent_level: expected %0d, actual %0d", want, exponent_level);
          errors++;
        end
      end
    end
  end

  task automatic send_pixel(logic [RW-1:0] a, logic [RW-1:0] b);
    int gap;
    gap = $urandom_range(0, 9);
    repeat (gap) @(posedge clk);
    while (busy) @(posedge clk);
    level_q.push_back(pixel_level(a, b));
    start <= 1'b1;
    rate_a <= a;
    rate_b <= b;
    @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (level_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SEQ_PATTERN: pattern_q = val;
      REG_SEQ_LENGTH: length_q = val[4:0];
      REG_ITER_COUNT: count_q = val[11:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [RW-1:0] rand_rate();
    case ($urandom_range(0, 5))
      0: return RW'($urandom());
      1: return RATE_MAX - RW'($urandom_range(0, 3));
      default: return RW'($urandom_range(40000000, 67108864));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_pixel(27'd58720256, 27'd50331648);
    send_pixel(27'd0, 27'd0);
    send_pixel(RATE_MAX, RATE_MAX);
    send_pixel('1, '1);
    send_pixel(27'd33554432, 27'd16777216);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_ITER_COUNT, 16'd0);
    send_pixel(27'd60000000, 27'd55000000);
    wait_idle();
    write_reg(REG_ITER_COUNT, 16'd1);
    write_reg(REG_SEQ_LENGTH, 16'd0);
    write_reg(REG_SEQ_PATTERN, 16'hFFFF);
    send_pixel(RATE_MAX, 27'd1);
    send_pixel(27'd1, RATE_MAX);
    wait_idle();
    write_reg(REG_ITER_COUNT, 16'hFFFF);
    write_reg(REG_SEQ_LENGTH, 16'h001F);
    write_reg(REG_SEQ_PATTERN, 16'h0000);
    send_pixel(27'd58720256, 27'd62914560);
    send_pixel(27'd0, 27'h5555555);
    wait_idle();
    write_reg(REG_SEQ_LENGTH, 16'd16);
    write_reg(REG_SEQ_PATTERN, 16'hAAAA);
    write_reg(REG_ITER_COUNT, 16'd4);
    send_pixel(27'h2AAAAAA, 27'h5555555);
    wait_idle();
  endtask

  task automatic test_random_pixels();
    for (int p = 0; p < 30; p++) begin
      write_reg(REG_SEQ_PATTERN, CFG_W'($urandom()));
      write_reg(REG_SEQ_LENGTH, CFG_W'($urandom_range(0, 31)));
      write_reg(REG_ITER_COUNT, (p % 10 == 9) ? CFG_W'($urandom_range(1000, 4095))
                                             : CFG_W'($urandom_range(0, 60)));
      for (int k = 0; k < 50; k++) send_pixel(rand_rate(), rand_rate());
      wait_idle();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_pixels();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
